>>> hdl/fmoc_pkg.sv
// Shared constants, types and codes for the FM-index occurrence checkpoint interleaver.
`default_nettype none
package fmoc_pkg;
   localparam int SYMBOL_KINDS   = 24;
   localparam int LANES          = 4;
   localparam int BYTE_W         = 8;
   localparam int WORD_W         = LANES * BYTE_W;
   localparam int SYM_W          = 5;
   localparam int NVALID_W       = 3;
   localparam int COUNT_W        = 64;
   localparam int ADD_W          = 3;
   localparam int INTERVAL_W     = 11;
   localparam int PHASE_W        = 10;
   localparam int MAX_INTERVAL   = 1024;
   localparam int INTERVAL_RESET = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   // register index as decoded from the byte address
   localparam logic REG_INTERVAL = 1'b0;

   typedef enum logic {
      KIND_COUNT = 1'b0,
      KIND_WORD  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRE,
      ST_WORD,
      ST_POST
   } state_type;

   // what one lane found in its byte
   typedef struct packed {
      logic [SYMBOL_KINDS-1:0] hit;
      logic                    bad;
   } lane_hit_type;
endpackage
`default_nettype wire

>>> hdl/fmoc_if.sv
// Valid/ready channel interfaces for the input words and the result items.
`default_nettype none
interface fmoc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [fmoc_pkg::WORD_W-1:0]           packed_word;
   logic [fmoc_pkg::NVALID_W-1:0]         valid_symbols;
   logic                                  last_word;

   modport source (output valid, packed_word, valid_symbols, last_word, input ready);
   modport sink   (input valid, packed_word, valid_symbols, last_word, output ready);
endinterface

interface fmoc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  kind;
   logic [fmoc_pkg::COUNT_W-1:0]          value;
   logic [fmoc_pkg::SYM_W-1:0]            symbol_index;
   logic                                  bad_symbol;
   logic                                  run_end;

   modport source (output valid, kind, value, symbol_index, bad_symbol, run_end,
                   input ready);
   modport sink   (input valid, kind, value, symbol_index, bad_symbol, run_end,
                   output ready);
endinterface
`default_nettype wire

>>> hdl/fmoc_lane.sv
// One symbol lane: decodes a byte into a one-hot count increment and a bad flag.
`default_nettype none
module fmoc_lane (
   input  wire logic [fmoc_pkg::BYTE_W-1:0] sym,
   input  wire logic                        lane_en,
   output fmoc_pkg::lane_hit_type           result
);
   import fmoc_pkg::*;

   logic in_alpha;

   assign in_alpha = sym < BYTE_W'(SYMBOL_KINDS);

   always_comb begin
      for (int s = 0; s < SYMBOL_KINDS; s++) begin
         result.hit[s] = lane_en && in_alpha && (sym[SYM_W-1:0] == SYM_W'(s));
      end
      result.bad = lane_en && !in_alpha;
   end
endmodule
`default_nettype wire

>>> hdl/fmoc_merge.sv
// Merges lane hits into the per-symbol running counts and serves one count per cycle.
`default_nettype none
module fmoc_merge (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fmoc_pkg::lane_hit_type        lane_hits [fmoc_pkg::LANES],
   input  wire logic                          count_en,
   input  wire logic                          clear,
   input  wire logic [fmoc_pkg::SYM_W-1:0]    rd_idx,
   output logic      [fmoc_pkg::COUNT_W-1:0]  rd_count
);
   import fmoc_pkg::*;

   logic [COUNT_W-1:0] count_ff [SYMBOL_KINDS];
   logic [COUNT_W-1:0] count_in [SYMBOL_KINDS];
   logic [ADD_W-1:0]   add      [SYMBOL_KINDS];

   always_comb begin
      for (int s = 0; s < SYMBOL_KINDS; s++) begin
         add[s] = '0;
         for (int l = 0; l < LANES; l++) begin
            add[s] = add[s] + ADD_W'(lane_hits[l].hit[s]);
         end
         count_in[s] = count_ff[s] + COUNT_W'(add[s]);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SYMBOL_KINDS; s++) begin
         if (reset || clear) begin
            count_ff[s] <= '0;
         end else if (count_en) begin
            count_ff[s] <= count_in[s];
         end
      end
   end

   always_comb begin
      rd_count = '0;
      for (int s = 0; s < SYMBOL_KINDS; s++) begin
         if (rd_idx == SYM_W'(s)) begin
            rd_count = count_ff[s];
         end
      end
   end
endmodule
`default_nettype wire

>>> hdl/fm_index_occ_checkpoint_interleave.sv
// Top level: word sequencer, four symbol lanes, count merge and the result register.
// Order: an item taken while idle moves the sequencer state, then its first result is registered;
// after that one result a cycle while the receiver is ready. No new word is taken before its results
// are emitted; a checkpoint word adds SYMBOL_KINDS count results, a last word another SYMBOL_KINDS.
// Reset (synchronous): counts and word phase cleared, interval register set to 32.
`default_nettype none
module fm_index_occ_checkpoint_interleave (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fmoc_req_if.sink                               req_bus,
   fmoc_rsp_if.source                             rsp_bus,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [fmoc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [fmoc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [fmoc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);
   import fmoc_pkg::*;

   localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(SYMBOL_KINDS - 1);

   // config
   logic [INTERVAL_W-1:0] interval_ff;
   logic [INTERVAL_W-1:0] interval_eff;
   logic                  csr_write;

   // item hold
   logic [WORD_W-1:0]     word_ff;
   logic [NVALID_W-1:0]   nvalid_ff;
   logic [NVALID_W-1:0]   nvalid_in;
   logic                  last_ff;

   // sequencer
   state_type             state_ff;
   state_type             state_in;
   logic [SYM_W-1:0]      idx_ff;
   logic [PHASE_W-1:0]    phase_ff;
   logic [INTERVAL_W-1:0] phase_plus;
   logic                  accept;
   logic                  emit;
   logic                  count_en;
   logic                  clear;
   logic                  idx_last;

   // lanes
   lane_hit_type          lane_hits [LANES];
   logic                  bad;
   logic [COUNT_W-1:0]    rd_count;

   // result register
   logic                  rsp_valid_ff;
   logic                  kind_ff;
   logic [COUNT_W-1:0]    value_ff;
   logic [SYM_W-1:0]      sym_ff;
   logic                  bad_ff;
   logic                  end_ff;
   kind_type              out_kind;
   logic [COUNT_W-1:0]    out_value;
   logic [SYM_W-1:0]      out_sym;
   logic                  out_end;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_INTERVAL);
   assign prdata    = (paddr[2] == REG_INTERVAL) ? CSR_DATA_W'(interval_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_W'(INTERVAL_RESET);
      end else if (csr_write) begin
         interval_ff <= pwdata[INTERVAL_W-1:0];
      end
   end

   always_comb begin
      if (interval_ff == '0) begin
         interval_eff = INTERVAL_W'(1);
      end else if (interval_ff > INTERVAL_W'(MAX_INTERVAL)) begin
         interval_eff = INTERVAL_W'(MAX_INTERVAL);
      end else begin
         interval_eff = interval_ff;
      end
   end

   // ---------------- item intake ----------------
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign nvalid_in     = (req_bus.valid_symbols > NVALID_W'(LANES)) ?
                          NVALID_W'(LANES) : req_bus.valid_symbols;

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff   <= req_bus.packed_word;
         nvalid_ff <= nvalid_in;
         last_ff   <= req_bus.last_word;
      end
   end

   // ---------------- lanes ----------------
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      fmoc_lane u_lane (
         .sym     (word_ff[(LANES-1-g)*BYTE_W +: BYTE_W]),
         .lane_en (nvalid_ff > NVALID_W'(g)),
         .result  (lane_hits[g])
      );
   end

   always_comb begin
      bad = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         bad = bad | lane_hits[l].bad;
      end
   end

   fmoc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_hits (lane_hits),
      .count_en  (count_en),
      .clear     (clear),
      .rd_idx    (idx_ff),
      .rd_count  (rd_count)
   );

   // ---------------- sequencer ----------------
   assign emit     = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign idx_last = (idx_ff == LAST_SYM);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (phase_ff == '0) ? ST_PRE : ST_WORD;
            end
         end
         ST_PRE: begin
            if (emit && idx_last) begin
               state_in = ST_WORD;
            end
         end
         ST_WORD: begin
            if (emit) begin
               state_in = last_ff ? ST_POST : ST_IDLE;
            end
         end
         ST_POST: begin
            if (emit && idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_kind  = KIND_COUNT;
      out_value = rd_count;
      out_sym   = idx_ff;
      out_end   = 1'b0;
      count_en  = 1'b0;
      clear     = 1'b0;
      case (state_ff)
         ST_PRE: begin
         end
         ST_WORD: begin
            out_kind  = KIND_WORD;
            out_value = COUNT_W'(word_ff);
            out_sym   = '0;
            out_end   = !last_ff;
            count_en  = emit;
         end
         ST_POST: begin
            out_end = idx_last;
            clear   = emit && idx_last;
         end
         ST_IDLE: begin
         end
         default: begin
         end
      endcase
   end

   assign phase_plus = INTERVAL_W'(phase_ff) + INTERVAL_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (emit && (state_ff == ST_PRE || state_ff == ST_POST)) begin
            idx_ff <= idx_last ? '0 : idx_ff + SYM_W'(1);
         end
         if (clear) begin
            phase_ff <= '0;
         end else if (count_en) begin
            phase_ff <= (phase_plus >= interval_eff) ? '0 : phase_plus[PHASE_W-1:0];
         end
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= out_kind;
         value_ff <= out_value;
         sym_ff   <= out_sym;
         bad_ff   <= bad;
         end_ff   <= out_end;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = kind_ff;
   assign rsp_bus.value        = value_ff;
   assign rsp_bus.symbol_index = sym_ff;
   assign rsp_bus.bad_symbol   = bad_ff;
   assign rsp_bus.run_end      = end_ff;
endmodule
`default_nettype wire
